FILE: hdl/rms_pkg.sv
// ============================================================================
// rms_pkg
// Shared constants and types for the rolling mean and deviation block.
// ============================================================================
package rms_pkg;
    localparam int WINDOW_DEF      = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int OUT_BITS        = 24;
    localparam int SQRT_IN_BITS    = 64;
    localparam int SQRT_OUT_BITS   = 32;
    localparam int DIV_BITS        = 64;
    localparam logic [OUT_BITS-1:0] STD_MAX = '1;

    typedef enum logic [2:0] {
        t_IDLE  = 3'd0,
        t_CLEAR = 3'd1,
        t_READ  = 3'd2,
        t_UPD   = 3'd3,
        t_MUL   = 3'd4,
        t_DIV   = 3'd5,
        t_SQRT  = 3'd6,
        t_OUT   = 3'd7
    } t_state;
endpackage

FILE: hdl/rms_div.sv
// ============================================================================
// rms_div
// Division by a constant through reciprocal multiplication, one 32 by 32
// partial product per cycle.
// ============================================================================
module rms_div #(
    parameter longint unsigned DEN = longint'(rms_pkg::WINDOW_DEF)
                                     * longint'(rms_pkg::WINDOW_DEF - 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rms_pkg::DIV_BITS-1:0]      i_num,
    output logic                              o_done,
    output logic [rms_pkg::DIV_BITS-1:0]      o_quot
);
    localparam int DB = rms_pkg::DIV_BITS;
    localparam int HB = DB / 2;
    // The rounded-up reciprocal gives the exact quotient for numerators below 2^64 / DEN.
    localparam logic [DB-1:0] RECIP = (DB)'({DB{1'b1}} / DEN + 64'd1);

    logic [DB-1:0]   r_num;
    logic [2*DB-1:0] r_acc;
    logic [1:0]      r_step;
    logic            r_busy, r_done;
    logic [HB-1:0]   n_a, n_b;
    logic [DB-1:0]   n_pp;
    logic [2*DB-1:0] n_term;

    assign n_a  = r_step[0] ? r_num[DB-1:HB] : r_num[HB-1:0];
    assign n_b  = r_step[1] ? RECIP[DB-1:HB] : RECIP[HB-1:0];
    assign n_pp = (DB)'(n_a) * (DB)'(n_b);

    always_comb begin
        case (r_step)
            2'd0:    n_term = {{DB{1'b0}}, n_pp};
            2'd3:    n_term = {n_pp, {DB{1'b0}}};
            default: n_term = {{HB{1'b0}}, n_pp, {HB{1'b0}}};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_num;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc  <= r_acc + n_term;
                r_step <= r_step + 1'b1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_acc[2*DB-1:DB];
endmodule

FILE: hdl/rms_sqrt.sv
// ============================================================================
// rms_sqrt
// Integer square root, one result bit per cycle.
// ============================================================================
module rms_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [rms_pkg::SQRT_IN_BITS-1:0]    i_val,
    output logic                                o_done,
    output logic [rms_pkg::SQRT_OUT_BITS-1:0]   o_root
);
    localparam int CW = $clog2(rms_pkg::SQRT_OUT_BITS + 1);
    logic [rms_pkg::SQRT_IN_BITS-1:0]  r_v, r_root, r_bit;
    logic [CW-1:0]                     r_cnt;
    logic                              r_busy, r_done;
    logic [rms_pkg::SQRT_IN_BITS-1:0]  n_trial;

    assign n_trial = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(rms_pkg::SQRT_OUT_BITS);
                r_v    <= i_val;
                r_root <= '0;
                r_bit  <= {2'b01, {(rms_pkg::SQRT_IN_BITS-2){1'b0}}};
            end else if (r_busy) begin
                if (r_v >= n_trial) begin
                    r_v    <= r_v - n_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_root = r_root[rms_pkg::SQRT_OUT_BITS-1:0];
endmodule

FILE: hdl/rolling_mean_stdev.sv
// ============================================================================
// rolling_mean_stdev
// Rolling window mean and sample standard deviation over signed samples.
// ============================================================================
// Samples arrive on the i_sample channel (valid/ready); each request yields
// one result on the o_mean/o_std_dev channel (valid/ready). The window lives
// in a synchronous RAM of WINDOW entries; running sum and sum of squares sit
// in registers. A sample passes through the states that read and update the
// window, form the numerators, divide them by the constant denominators in
// the reciprocal multipliers, take the one-bit-per-cycle square root and
// load the output register. No new sample is taken until the result of the
// last one is in the output register, so the block works on one at a time.
// Reset, and every write on the configuration channel, loads the window
// with init_value: a clearing pass over every entry during which no sample
// is taken. Configuration is taken only while no result is pending. While the
// receiver stalls, the result holds in the output register, one more sample
// is processed and its result waits in the last stage with no sample taken.
module rolling_mean_stdev #(
    parameter int WINDOW      = rms_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = rms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [rms_pkg::OUT_BITS-1:0] o_mean,
    output logic        [rms_pkg::OUT_BITS-1:0] o_std_dev
);
    localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WB  = $clog2(WINDOW + 1);
    localparam int SW  = SAMPLE_BITS + WB + 1;
    localparam int QW  = 2 * SAMPLE_BITS + WB + 1;
    localparam int DB  = rms_pkg::DIV_BITS;
    localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);
    localparam longint unsigned DEN = longint'(WINDOW) * longint'(WINDOW - 1);
    localparam longint unsigned MDEN = longint'(WINDOW);
    localparam logic [DB-1:0] MSC_BIAS = (DB)'(WINDOW) << (SAMPLE_BITS + 7);
    localparam longint MEAN_BIAS = longint'(1) <<< (SAMPLE_BITS + 7);

    logic signed [SAMPLE_BITS-1:0] mem [WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd, r_init, r_x;
    logic [AW-1:0] r_pos, r_clr;
    logic [WB-1:0] r_fill;
    logic signed [SW-1:0] r_sum;
    logic [QW-1:0] r_sq;
    rms_pkg::t_state r_st, n_st;
    logic r_oval;
    logic signed [rms_pkg::OUT_BITS-1:0] r_mean, r_omean;
    logic [rms_pkg::OUT_BITS-1:0] r_sd, r_osd;

    logic div_start, div_done, mdiv_done, sq_start, sq_done, out_load;
    logic [DB-1:0] div_q, mdiv_q;
    logic [rms_pkg::SQRT_OUT_BITS-1:0] root;
    logic signed [2*SAMPLE_BITS-1:0] n_sqx, n_sqo, n_cfg_sq;
    logic signed [SW-1:0] n_sum;
    logic [QW-1:0] n_sq;
    logic signed [2*SW-1:0] n_sum2;
    logic [DB-1:0] n_d, n_msc;
    logic signed [63:0] n_mq;

    assign o_cfg_ready = (r_st == rms_pkg::t_IDLE) && !r_oval;
    assign o_ready     = (r_st == rms_pkg::t_IDLE) && !i_cfg_valid;
    assign out_load    = (r_st == rms_pkg::t_OUT) && (!r_oval || i_ready);

    always_comb begin
        n_st = r_st;
        case (r_st)
            rms_pkg::t_IDLE:  begin
                if (i_cfg_valid && o_cfg_ready) n_st = rms_pkg::t_CLEAR;
                else if (i_valid && o_ready)    n_st = rms_pkg::t_READ;
            end
            rms_pkg::t_CLEAR: if (r_clr == LAST) n_st = rms_pkg::t_IDLE;
            rms_pkg::t_READ:  n_st = rms_pkg::t_UPD;
            rms_pkg::t_UPD:   n_st = rms_pkg::t_MUL;
            rms_pkg::t_MUL:   n_st = rms_pkg::t_DIV;
            rms_pkg::t_DIV:   if (div_done) n_st = rms_pkg::t_SQRT;
            rms_pkg::t_SQRT:  if (sq_done) n_st = rms_pkg::t_OUT;
            rms_pkg::t_OUT:   if (out_load) n_st = rms_pkg::t_IDLE;
            default:          n_st = rms_pkg::t_IDLE;
        endcase
    end

    always_comb begin
        div_start = (r_st == rms_pkg::t_MUL);
        sq_start  = (r_st == rms_pkg::t_DIV) && div_done;
    end

    assign n_sqx    = r_x * r_x;
    assign n_sqo    = r_rd * r_rd;
    assign n_cfg_sq = (2*SAMPLE_BITS)'(i_cfg_data) * (2*SAMPLE_BITS)'(i_cfg_data);
    assign n_sum    = r_sum + SW'(r_x) - SW'(r_rd);
    assign n_sq     = r_sq + QW'(unsigned'(n_sqx)) - QW'(unsigned'(n_sqo));
    assign n_sum2   = (2*SW)'(r_sum) * (2*SW)'(r_sum);
    assign n_d      = (DB)'(r_sq) * (DB)'(WINDOW) - (DB)'(unsigned'(n_sum2));
    // The sum is offset so that the mean divider only sees non-negative values.
    assign n_msc    = ((DB)'(r_sum) << 8) + MSC_BIAS;
    assign n_mq     = signed'(mdiv_q) - MEAN_BIAS;

    always_ff @(posedge i_clk) begin
        if (r_st == rms_pkg::t_CLEAR) mem[r_clr] <= r_init;
        else if (r_st == rms_pkg::t_UPD) mem[r_pos] <= r_x;
        r_rd <= mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= rms_pkg::t_CLEAR;
            r_init <= '0;
            r_clr  <= '0;
            r_pos  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_oval <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out_load) r_oval <= 1'b1;
            else if (r_oval && i_ready) r_oval <= 1'b0;
            case (r_st)
                rms_pkg::t_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        r_init <= i_cfg_data;
                        r_clr  <= '0;
                        r_pos  <= '0;
                        r_fill <= '0;
                        r_sum  <= SW'(i_cfg_data) * SW'(WINDOW);
                        r_sq   <= QW'(unsigned'(n_cfg_sq)) * QW'(WINDOW);
                    end else if (i_valid && o_ready) begin
                        r_x <= i_sample;
                    end
                end
                rms_pkg::t_CLEAR: r_clr <= r_clr + 1'b1;
                rms_pkg::t_UPD: begin
                    r_sum <= n_sum;
                    r_sq  <= n_sq;
                    r_pos <= (r_pos == LAST) ? '0 : r_pos + 1'b1;
                    if (r_fill != WB'(WINDOW)) r_fill <= r_fill + 1'b1;
                end
                rms_pkg::t_DIV: if (div_done) begin
                    if (n_mq > 64'sd8388607)       r_mean <= 24'sh7FFFFF;
                    else if (n_mq < -64'sd8388608) r_mean <= 24'sh800000;
                    else                           r_mean <= n_mq[23:0];
                end
                rms_pkg::t_SQRT: if (sq_done) begin
                    r_sd <= (root > 32'(rms_pkg::STD_MAX)) ? rms_pkg::STD_MAX : root[23:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_omean <= r_mean;
            r_osd   <= r_sd;
        end
    end

    rms_div #(.DEN(DEN)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(n_d << 16),
        .o_done(div_done), .o_quot(div_q)
    );

    rms_div #(.DEN(MDEN)) u_mdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(n_msc),
        .o_done(mdiv_done), .o_quot(mdiv_q)
    );

    rms_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_val(div_q), .o_done(sq_done), .o_root(root)
    );

    assign o_valid   = r_oval;
    assign o_mean    = r_omean;
    assign o_std_dev = r_osd;

    a_cfg_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_valid) else $error("configuration taken with result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_mean) && $stable(o_std_dev)))
        else $error("result changed under stall");
    a_single_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_start && sq_start)) else $error("units started together");
    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done == mdiv_done) else $error("dividers out of step");
endmodule

FILE: tb/sv/testbench.sv
// ============================================================================
// Rolling mean and deviation testbench
// Drives signed samples and init_value writes through the valid/ready
// channels and checks every mean and deviation against a predictor of the
// window, running sum and sum of squares, under several idling patterns.
// ============================================================================
class rms_scoreboard;
    int               window_len;
    logic signed [15:0] window_vals[];
    int               wr_pos;
    longint           sum_acc;
    longint unsigned  sq_acc;
    logic [23:0]      mean_q[$];
    logic [23:0]      dev_q[$];
    int               errors;
    int               checked;

    function new(int n);
        window_len = n;
        window_vals = new[n];
        errors = 0;
        checked = 0;
        load(16'sd0);
    endfunction

    function longint unsigned sq_of(longint x);
        longint unsigned m;
        m = (x < 0) ? longint'(-x) : longint'(x);
        return m * m;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function void load(logic signed [15:0] v);
        for (int k = 0; k < window_len; k++) window_vals[k] = v;
        wr_pos = 0;
        sum_acc = longint'(v) * window_len;
        sq_acc = sq_of(longint'(v)) * window_len;
    endfunction

    function void note_sample(logic signed [15:0] x);
        longint old;
        longint scaled;
        longint q;
        longint unsigned d;
        longint unsigned sd;
        old = window_vals[wr_pos];
        window_vals[wr_pos] = x;
        wr_pos = (wr_pos + 1) % window_len;
        sum_acc = sum_acc + longint'(x) - old;
        sq_acc = sq_acc + sq_of(longint'(x)) - sq_of(old);
        scaled = sum_acc * 256;
        q = scaled / window_len;
        if ((scaled % window_len) != 0 && scaled < 0) q--;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        d = longint'(window_len) * sq_acc - sq_of(sum_acc);
        sd = int_sqrt((d * 65536) / (window_len * (window_len - 1)));
        if (sd > 24'hFFFFFF) sd = 24'hFFFFFF;
        mean_q.push_back(q[23:0]);
        dev_q.push_back(sd[23:0]);
    endfunction

    task report(string what, logic [23:0] got, logic [23:0] want);
        $display("error: %s got %h want %h", what, got, want);
        errors++;
    endtask

    task check_result(logic [23:0] m, logic [23:0] s);
        logic [23:0] em;
        logic [23:0] es;
        if (mean_q.size() == 0) begin
            report("unexpected result, mean", m, 24'h0);
        end else begin
            em = mean_q.pop_front();
            es = dev_q.pop_front();
            checked++;
            if (m !== em) report("mean", m, em);
            if (s !== es) report("std_dev", s, es);
        end
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic signed [15:0]  i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic signed [15:0]  i_sample = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [rms_pkg::OUT_BITS-1:0] o_mean;
    logic [rms_pkg::OUT_BITS-1:0] o_std_dev;

    rms_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold = 1'b0;
    int hold_count = 0;
    int cycles = 0;
    int samples_sent = 0;
    int cfg_writes = 0;

    localparam int CYCLE_LIMIT = 2000000;

    rolling_mean_stdev DUT (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("rolling_mean_stdev: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_mean, o_std_dev);
        if (long_hold) begin
            hold_count <= hold_count + 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task send_sample(logic signed [15:0] x);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= x;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_sample(x);
        samples_sent++;
    endtask

    task drain();
        i_valid <= 1'b0;
        while (sb.mean_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task write_init(logic signed [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.load(v);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    function logic signed [15:0] rand_sample();
        case ($urandom_range(3))
            0: return 16'sh7FFF - $urandom_range(3);
            1: return 16'sh8000 + $urandom_range(3);
            2: return $urandom_range(255) - 128;
            default: return $urandom();
        endcase
    endfunction

    task random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(199) == 0) write_init($urandom());
            send_sample(rand_sample());
        end
    endtask

    initial begin
        sb = new(rms_pkg::WINDOW_DEF);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        recv_stall_pct = 0;
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        for (int k = 0; k < 8; k++) send_sample(16'sh7FFF);
        for (int k = 0; k < 8; k++) send_sample(16'sh8000);
        write_init(16'sh7FFF);
        send_sample(16'sh8000);
        write_init(16'sh8000);
        send_sample(16'sh7FFF);
        write_init(-16'sd3);
        send_sample(16'sd5);

        random_phase(450, 0, 0);
        write_init(16'sh0000);
        random_phase(450, 51, 0);
        write_init(16'sh7FFF);
        random_phase(450, 0, 51);
        write_init(16'sh8000);
        random_phase(450, 26, 26);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 1'b1;
        fork
            begin
                for (int k = 0; k < 6; k++) send_sample(rand_sample());
            end
            begin
                while (hold_count < 600) @(posedge i_clk);
                long_hold = 1'b0;
            end
        join
        drain();
        for (int k = 0; k < 20; k++) send_sample(rand_sample());
        drain();
        repeat (200) @(posedge i_clk);

        $display("covered %0d samples and %0d init_value writes, %0d results checked",
                 samples_sent, cfg_writes, sb.checked);
        $display("idling: none, sender 51%%, receiver 51%%, both 26%%, long receiver hold");
        if (sb.errors == 0 && sb.mean_q.size() == 0) begin
            $display("rolling_mean_stdev: match");
        end else begin
            $display("%0d errors, %0d results outstanding", sb.errors, sb.mean_q.size());
            $display("rolling_mean_stdev: mismatch");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/rms_pkg.sv
hdl/rms_div.sv
hdl/rms_sqrt.sv
hdl/rolling_mean_stdev.sv
tb/sv/testbench.sv
